// File: hdl/mdc_pkg.sv
// Package for the cofactor determinant block: sizes and types shared
// by the sequencer and the datapath, and the sequencer's permutation helpers.
// No dependencies.
package mdc_pkg;

	localparam int MAX_SIZE   = 4;
	localparam int ENTRY_BITS = 12;
	localparam int DET_BITS   = 50;

	localparam int FIELD_IDX_BITS = 2;
	localparam int VALUE_BITS     = 12;
	localparam int CFG_BITS       = 3;
	localparam int PADDR_BITS     = 3;
	localparam int PDATA_BITS     = 32;

	localparam int IDX_BITS  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int SIZE_BITS = $clog2(MAX_SIZE + 1);
	localparam int DEPTH     = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PROD_BITS = MAX_SIZE * ENTRY_BITS;
	localparam int WIDE_BITS = (PROD_BITS > DET_BITS) ? PROD_BITS : DET_BITS;

	localparam logic [CFG_BITS-1:0]     SIZE_RESET      = CFG_BITS'(3);
	localparam logic [PADDR_BITS-3:0]   REG_MATRIX_SIZE = '0;

	typedef logic [IDX_BITS-1:0] idx_t;
	typedef idx_t [MAX_SIZE-1:0] digits_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic neg;
		logic live;
	} rd_tag_t;

	typedef struct packed {
		logic rd_valid;
		logic first;
		logic live;
		logic acc_add;
		logic acc_neg;
		logic acc_clear;
		logic result_load;
	} mac_ctl_t;

	function automatic logic [ADDR_BITS-1:0] entry_addr(idx_t row, idx_t col);
		return ADDR_BITS'(int'(row) * MAX_SIZE + int'(col));
	endfunction

	// Lehmer digit of each row selects among the columns still free
	function automatic idx_t pick_col(digits_t d, idx_t row);
		logic [MAX_SIZE-1:0] used;
		idx_t res;
		idx_t sel;
		int cnt;
		used = '0;
		res  = '0;
		for (int r = 0; r < MAX_SIZE; r++) begin
			cnt = 0;
			sel = '0;
			for (int c = 0; c < MAX_SIZE; c++) begin
				if (!used[c]) begin
					if (cnt == int'(d[r]))
						sel = IDX_BITS'(c);
					cnt++;
				end
			end
			if (r <= int'(row)) begin
				used[sel] = 1'b1;
				if (r == int'(row))
					res = sel;
			end
		end
		return res;
	endfunction

	function automatic logic perm_done(digits_t d, logic [SIZE_BITS-1:0] n);
		logic done;
		done = 1'b1;
		for (int r = 0; r < MAX_SIZE; r++) begin
			if (r < int'(n) && int'(d[r]) != int'(n) - 1 - r)
				done = 1'b0;
		end
		return done;
	endfunction

	function automatic digits_t next_digits(digits_t d, logic [SIZE_BITS-1:0] n);
		digits_t res;
		logic carry;
		res   = d;
		carry = 1'b1;
		for (int r = MAX_SIZE - 1; r >= 0; r--) begin
			if (carry && r < int'(n) - 1) begin
				if (int'(res[r]) == int'(n) - 1 - r) begin
					res[r] = '0;
				end else begin
					res[r] = res[r] + 1'b1;
					carry  = 1'b0;
				end
			end
		end
		return res;
	endfunction

	// Inversion count of a permutation is the sum of its Lehmer digits
	function automatic logic perm_odd(digits_t d);
		logic p;
		p = 1'b0;
		for (int r = 0; r < MAX_SIZE; r++)
			p = p ^ d[r][0];
		return p;
	endfunction

endpackage

// File: hdl/mdc_req_if.sv
// Request channel of the determinant block: one matrix entry write with
// an optional compute flag. Depends on mdc_pkg.
interface mdc_req_if;
	import mdc_pkg::*;

	logic                             valid;
	logic                             ready;
	logic [FIELD_IDX_BITS-1:0]        row_index;
	logic [FIELD_IDX_BITS-1:0]        col_index;
	logic signed [VALUE_BITS-1:0]     entry_value;
	logic                             compute_now;

	modport source (
		output valid, row_index, col_index, entry_value, compute_now,
		input  ready
	);
	modport sink (
		input  valid, row_index, col_index, entry_value, compute_now,
		output ready
	);
endinterface

// File: hdl/mdc_rsp_if.sv
// Result channel of the determinant block: one signed determinant.
// Depends on mdc_pkg.
interface mdc_rsp_if;
	import mdc_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [DET_BITS-1:0]   determinant_value;

	modport source (
		output valid, determinant_value,
		input  ready
	);
	modport sink (
		input  valid, determinant_value,
		output ready
	);
endinterface

// File: hdl/mdc_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module mdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: hdl/mdc_cfg.sv
// APB register file of the determinant block: the matrix order register
// and its saturated effective size. Depends on mdc_pkg.
module mdc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mdc_pkg::PADDR_BITS-1:0]     paddr,
	input  logic [mdc_pkg::PDATA_BITS-1:0]     pwdata,
	output logic [mdc_pkg::PDATA_BITS-1:0]     prdata,
	output logic                               pready,
	output logic [mdc_pkg::SIZE_BITS-1:0]      size_n
);
	import mdc_pkg::*;

	logic [CFG_BITS-1:0]     size_q;
	logic [PADDR_BITS-3:0]   reg_idx;
	logic                    wr_en;

	assign reg_idx = paddr[PADDR_BITS-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && (reg_idx == REG_MATRIX_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (wr_en) begin
			size_q <= pwdata[CFG_BITS-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MATRIX_SIZE: prdata = PDATA_BITS'(size_q);
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		if (size_q == '0)
			size_n = SIZE_BITS'(1);
		else if (int'(size_q) > MAX_SIZE)
			size_n = SIZE_BITS'(MAX_SIZE);
		else
			size_n = SIZE_BITS'(size_q);
	end
endmodule

// File: hdl/mdc_ctrl.sv
// Sequencer of the determinant block: request handshake, entry writes,
// entry valid bits and the permutation walk that drives store reads.
// Depends on mdc_pkg and mdc_req_if.
module mdc_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	mdc_req_if.sink                          req,
	input  logic [mdc_pkg::SIZE_BITS-1:0]    size_n,
	input  logic                             slot_free,
	output logic                             ram_we,
	output logic [mdc_pkg::ADDR_BITS-1:0]    ram_addr,
	output logic [mdc_pkg::ENTRY_BITS-1:0]   ram_wdata,
	output mdc_pkg::mac_ctl_t                mac
);
	import mdc_pkg::*;

	state_t                  state_q, state_d;
	idx_t                    row_q, row_d;
	digits_t                 digit_q, digit_d;
	logic [DEPTH-1:0]        live_q;
	rd_tag_t                 tag_s1;
	logic                    add_s2;
	logic                    neg_s2;
	logic                    wr_ok;
	logic                    last_row;
	logic                    acc_clear;
	logic                    result_load;
	idx_t                    top_row;
	idx_t                    rd_col;
	logic [ADDR_BITS-1:0]    wr_addr;
	logic [ADDR_BITS-1:0]    rd_addr;

	assign top_row   = IDX_BITS'(size_n - 1'b1);
	assign last_row  = (row_q == top_row);
	assign wr_ok     = (int'(req.row_index) < MAX_SIZE) && (int'(req.col_index) < MAX_SIZE);
	assign wr_addr   = entry_addr(IDX_BITS'(req.row_index), IDX_BITS'(req.col_index));
	assign rd_col    = pick_col(digit_q, row_q);
	assign rd_addr   = entry_addr(row_q, rd_col);
	assign ram_wdata = ENTRY_BITS'($unsigned(req.entry_value));

	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		digit_d     = digit_q;
		req.ready   = 1'b0;
		ram_we      = 1'b0;
		ram_addr    = rd_addr;
		acc_clear   = 1'b0;
		result_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				ram_addr  = wr_addr;
				ram_we    = req.valid && wr_ok;
				if (req.valid && req.compute_now) begin
					state_d   = ST_READ;
					row_d     = '0;
					digit_d   = '0;
					acc_clear = 1'b1;
				end
			end
			ST_READ: begin
				if (last_row) begin
					row_d = '0;
					if (perm_done(digit_q, size_n))
						state_d = ST_FLUSH;
					else
						digit_d = next_digits(digit_q, size_n);
				end else begin
					row_d = row_q + 1'b1;
				end
			end
			ST_FLUSH: begin
				if (!tag_s1.valid && !add_s2 && slot_free) begin
					result_load = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			digit_q <= '0;
			live_q  <= '0;
			tag_s1  <= '0;
			add_s2  <= 1'b0;
			neg_s2  <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			digit_q <= digit_d;
			if (ram_we)
				live_q[wr_addr] <= 1'b1;
			tag_s1.valid <= (state_q == ST_READ);
			tag_s1.first <= (row_q == '0);
			tag_s1.last  <= last_row;
			tag_s1.neg   <= perm_odd(digit_q);
			tag_s1.live  <= live_q[rd_addr];
			add_s2       <= tag_s1.valid && tag_s1.last;
			neg_s2       <= tag_s1.neg;
		end
	end

	assign mac.rd_valid    = tag_s1.valid;
	assign mac.first       = tag_s1.first;
	assign mac.live        = tag_s1.live;
	assign mac.acc_add     = add_s2;
	assign mac.acc_neg     = neg_s2;
	assign mac.acc_clear   = acc_clear;
	assign mac.result_load = result_load;
endmodule

// File: hdl/mdc_mac.sv
// Datapath of the determinant block: shared multiplier for permutation
// products, signed accumulator and result register.
// Depends on mdc_pkg and mdc_rsp_if.
module mdc_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mdc_pkg::mac_ctl_t                mac,
	input  logic [mdc_pkg::ENTRY_BITS-1:0]   rdata,
	mdc_rsp_if.source                        rsp,
	output logic                             slot_free
);
	import mdc_pkg::*;

	logic signed [ENTRY_BITS-1:0]              entry;
	logic signed [PROD_BITS-1:0]               mult;
	logic signed [PROD_BITS-1:0]               prod_q;
	logic signed [WIDE_BITS-1:0]               prod_wide;
	logic signed [DET_BITS-1:0]                term;
	logic signed [DET_BITS-1:0]                acc_q;
	logic signed [DET_BITS-1:0]                result_q;
	logic                                      valid_q;

	assign entry     = mac.live ? $signed(rdata) : '0;
	assign mult      = PROD_BITS'(prod_q * entry);
	assign prod_wide = WIDE_BITS'(prod_q);
	assign term      = prod_wide[DET_BITS-1:0];

	always_ff @(posedge clk) begin
		if (mac.rd_valid)
			prod_q <= mac.first ? PROD_BITS'(entry) : mult;
		if (mac.acc_clear)
			acc_q <= '0;
		else if (mac.acc_add)
			acc_q <= mac.acc_neg ? acc_q - term : acc_q + term;
		if (mac.result_load)
			result_q <= acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (mac.result_load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign slot_free             = !valid_q || rsp.ready;
	assign rsp.valid             = valid_q;
	assign rsp.determinant_value = result_q;
endmodule

// File: hdl/matrix_determinant_cofactor.sv
// Determinant as the signed sum over all column permutations of a 4x4 store of signed entries.
// A write request is taken whenever the block is idle; a compute request walks all n! column
// permutations, n store reads each through the one RAM port and the shared
// multiplier, and loads the result once the pipeline is drained and the result slot is free.
// The block takes the next request as the result is loaded; an unread result holds back that load.
// Reset clears the entry valid bits, so the whole store reads as zero; order resets to 3.
module matrix_determinant_cofactor (
	input  logic                               clk,
	input  logic                               arst_n,
	mdc_req_if.sink                            req,
	mdc_rsp_if.source                          rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mdc_pkg::PADDR_BITS-1:0]     paddr,
	input  logic [mdc_pkg::PDATA_BITS-1:0]     pwdata,
	output logic [mdc_pkg::PDATA_BITS-1:0]     prdata,
	output logic                               pready
);
	import mdc_pkg::*;

	logic [SIZE_BITS-1:0]    size_n;
	logic                    slot_free;
	logic                    ram_we;
	logic [ADDR_BITS-1:0]    ram_addr;
	logic [ENTRY_BITS-1:0]   ram_wdata;
	logic [ENTRY_BITS-1:0]   ram_rdata;
	mac_ctl_t                mac;

	mdc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.size_n  (size_n)
	);

	mdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.size_n    (size_n),
		.slot_free (slot_free),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.mac       (mac)
	);

	mdc_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	mdc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.mac       (mac),
		.rdata     (ram_rdata),
		.rsp       (rsp),
		.slot_free (slot_free)
	);
endmodule
